// ===== hw/rtl/lkc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lkc_pkg
// Shared types and constants for the recency-ordered key counter.
// ----------------------------------------------------------------------------
package lkc_pkg;

    localparam int ENTRIES_DEFAULT = 64;
    localparam int KEY_W           = 32;
    localparam int CNT_W           = 32;
    localparam int POS_W           = 6;
    localparam int OCC_W           = 6;

    localparam logic FUNC_COUNT = 1'b0;
    localparam logic FUNC_READ  = 1'b1;

    typedef enum logic {
        OP_COUNT,
        OP_READ
    } op_t;

    typedef struct packed {
        op_t              op;
        logic [KEY_W-1:0] key;
        logic [POS_W-1:0] position;
    } item_t;

    typedef struct packed {
        logic             valid;
        item_t            item;
    } q_head_t;

    typedef struct packed {
        logic             found;
        logic [KEY_W-1:0] entry_key;
        logic [CNT_W-1:0] entry_count;
        logic             evicted;
        logic [KEY_W-1:0] evicted_key;
        logic [CNT_W-1:0] evicted_count;
        logic [OCC_W-1:0] occupancy;
    } result_t;

endpackage
`default_nettype wire

// ===== hw/rtl/lru_key_occurrence_counter.sv =====
`default_nettype none
// The back takes a new item only from idle, after its table sequence for the
// last item is done and when the output register is free or being taken.
// A two-beat input queue and an output register decouple both channels.
// Reset: asynchronous, empties queue and table (occupancy zero).
// ----------------------------------------------------------------------------
// lru_key_occurrence_counter
// Counts key occurrences in a recency-ordered table with oldest-entry eviction.
// ----------------------------------------------------------------------------
module lru_key_occurrence_counter
    import lkc_pkg::*;
#(
    parameter int ENTRIES = ENTRIES_DEFAULT
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_stall,
    input  wire logic             func,
    input  wire logic [KEY_W-1:0] key,
    input  wire logic [POS_W-1:0] position,
    output logic                  out_valid,
    input  wire logic             out_stall,
    output logic                  found,
    output logic [KEY_W-1:0]      entry_key,
    output logic [CNT_W-1:0]      entry_count,
    output logic                  evicted,
    output logic [KEY_W-1:0]      evicted_key,
    output logic [CNT_W-1:0]      evicted_count,
    output logic [OCC_W-1:0]      occupancy
);

    q_head_t head;
    logic    pop;
    result_t res;

    lkc_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .func     (func),
        .key      (key),
        .position (position),
        .head     (head),
        .pop      (pop)
    );

    lkc_back #(
        .ENTRIES (ENTRIES)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .res       (res)
    );

    assign found         = res.found;
    assign entry_key     = res.entry_key;
    assign entry_count   = res.entry_count;
    assign evicted       = res.evicted;
    assign evicted_key   = res.evicted_key;
    assign evicted_count = res.evicted_count;
    assign occupancy     = res.occupancy;

endmodule
`default_nettype wire

// ===== hw/rtl/lkc_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lkc_front
// Accepts input beats, classifies the function and queues them for the back.
// ----------------------------------------------------------------------------
module lkc_front
    import lkc_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_stall,
    input  wire logic             func,
    input  wire logic [KEY_W-1:0] key,
    input  wire logic [POS_W-1:0] position,
    output q_head_t               head,
    input  wire logic             pop
);

    item_t      slot_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] fill_reg;
    logic [1:0] fill_next;
    logic       push;
    logic       do_pop;
    item_t      new_item;

    always_comb
    begin
        new_item.op       = (func == FUNC_READ) ? OP_READ : OP_COUNT;
        new_item.key      = key;
        new_item.position = position;
    end

    assign in_stall   = (fill_reg == 2'd2);
    assign push       = in_valid && !in_stall;
    assign do_pop     = pop && (fill_reg != 2'd0);
    assign head.valid = (fill_reg != 2'd0);
    assign head.item  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg + 2'(push) - 2'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= new_item;
        end
    end

    fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= 2'd2)
        else $error("queue fill out of range");
    no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (fill_reg == 2'd0) |=> (fill_reg <= 2'd1))
        else $error("queue fill jumped from empty");
    push_counts: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !do_pop) |=> (fill_reg == $past(fill_reg) + 2'd1))
        else $error("push lost");

endmodule
`default_nettype wire

// ===== hw/rtl/lkc_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lkc_back
// Recency-ordered table in one memory: read, scan, update, shift and eviction.
// ----------------------------------------------------------------------------
module lkc_back
    import lkc_pkg::*;
#(
    parameter int ENTRIES = ENTRIES_DEFAULT
)
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire q_head_t head,
    output logic         pop,
    output logic         out_valid,
    input  wire logic    out_stall,
    output result_t      res
);

    localparam int AW = (ENTRIES > 2) ? $clog2(ENTRIES) : 1;
    localparam int PW = (AW > POS_W) ? AW : POS_W;
    localparam int DW = KEY_W + CNT_W;
    localparam logic [AW-1:0] HELD_MAX = AW'(ENTRIES - 1);

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD_ISS,
        S_RD_CAP,
        S_SCAN,
        S_CMP,
        S_INS,
        S_EV_ISS,
        S_EV_CAP,
        S_SH_RD,
        S_SH_WR
    } state_t;

    state_t           state_reg;
    logic [DW-1:0]    mem_reg [ENTRIES];
    logic [DW-1:0]    rdata_reg;
    logic [AW-1:0]    idx_reg;
    logic [AW-1:0]    held_reg;
    logic [KEY_W-1:0] new_key_reg;
    logic [CNT_W-1:0] new_cnt_reg;
    logic             out_valid_reg;
    result_t          res_reg;

    logic [AW-1:0]    rd_addr;
    logic             we;
    logic [AW-1:0]    wa;
    logic [DW-1:0]    wd;
    logic             out_take;
    logic             out_set;
    logic             pos_held;
    logic             last;
    logic [KEY_W-1:0] rd_key;
    logic [CNT_W-1:0] rd_cnt;

    assign out_take  = out_valid_reg && !out_stall;
    assign pop       = (state_reg == S_IDLE) && head.valid && (!out_valid_reg || out_take);
    assign out_valid = out_valid_reg;
    assign res       = res_reg;
    assign last      = (idx_reg == held_reg - AW'(1));
    assign rd_key    = rdata_reg[DW-1:CNT_W];
    assign rd_cnt    = rdata_reg[CNT_W-1:0];
    assign pos_held  = (PW'(head.item.position) < PW'(held_reg));
    assign out_set   = (pop && (head.item.op == OP_READ) && !pos_held)
                    || (state_reg == S_RD_CAP)
                    || (state_reg == S_INS)
                    || ((state_reg == S_SH_RD) && last);

    always_comb
    begin
        rd_addr = idx_reg;
        we      = 1'b0;
        wa      = idx_reg;
        wd      = {new_key_reg, new_cnt_reg};
        case (state_reg)
            S_EV_ISS: rd_addr = '0;
            S_SH_RD:
            begin
                rd_addr = idx_reg + AW'(1);
                we      = last;
            end
            S_SH_WR:
            begin
                we = 1'b1;
                wd = rdata_reg;
            end
            S_INS:
            begin
                we = 1'b1;
                wa = held_reg;
            end
            default: rd_addr = idx_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        rdata_reg <= mem_reg[rd_addr];
        if (we)
        begin
            mem_reg[wa] <= wd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            held_reg      <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_set || (out_valid_reg && !out_take);
            case (state_reg)
                S_IDLE:
                begin
                    if (pop)
                    begin
                        res_reg.found         <= 1'b0;
                        res_reg.entry_key     <= '0;
                        res_reg.entry_count   <= '0;
                        res_reg.evicted       <= 1'b0;
                        res_reg.evicted_key   <= '0;
                        res_reg.evicted_count <= '0;
                        res_reg.occupancy     <= OCC_W'(held_reg);
                        new_key_reg           <= head.item.key;
                        new_cnt_reg           <= CNT_W'(1);
                        idx_reg               <= (head.item.op == OP_READ) ?
                                                 AW'(head.item.position) : '0;
                        if (head.item.op == OP_READ)
                        begin
                            if (pos_held)
                            begin
                                state_reg <= S_RD_ISS;
                            end
                        end
                        else if (held_reg == '0)
                        begin
                            state_reg <= S_INS;
                        end
                        else
                        begin
                            state_reg <= S_SCAN;
                        end
                    end
                end
                S_RD_ISS: state_reg <= S_RD_CAP;
                S_RD_CAP:
                begin
                    res_reg.found       <= 1'b1;
                    res_reg.entry_key   <= rd_key;
                    res_reg.entry_count <= rd_cnt;
                    state_reg           <= S_IDLE;
                end
                S_SCAN: state_reg <= S_CMP;
                S_CMP:
                begin
                    if (rd_key == new_key_reg)
                    begin
                        new_cnt_reg <= (rd_cnt == '1) ? rd_cnt : rd_cnt + CNT_W'(1);
                        res_reg.found <= 1'b1;
                        state_reg     <= S_SH_RD;
                    end
                    else if (last)
                    begin
                        state_reg <= (held_reg == HELD_MAX) ? S_EV_ISS : S_INS;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + AW'(1);
                        state_reg <= S_SCAN;
                    end
                end
                S_INS:
                begin
                    held_reg            <= held_reg + AW'(1);
                    res_reg.entry_key   <= new_key_reg;
                    res_reg.entry_count <= new_cnt_reg;
                    res_reg.occupancy   <= OCC_W'(held_reg + AW'(1));
                    state_reg           <= S_IDLE;
                end
                S_EV_ISS: state_reg <= S_EV_CAP;
                S_EV_CAP:
                begin
                    res_reg.evicted       <= 1'b1;
                    res_reg.evicted_key   <= rd_key;
                    res_reg.evicted_count <= rd_cnt;
                    idx_reg               <= '0;
                    state_reg             <= S_SH_RD;
                end
                S_SH_RD:
                begin
                    if (last)
                    begin
                        res_reg.entry_key   <= new_key_reg;
                        res_reg.entry_count <= new_cnt_reg;
                        state_reg           <= S_IDLE;
                    end
                    else
                    begin
                        state_reg <= S_SH_WR;
                    end
                end
                S_SH_WR:
                begin
                    idx_reg   <= idx_reg + AW'(1);
                    state_reg <= S_SH_RD;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    held_bound: assert property (@(posedge clk) disable iff (!rst_n)
        held_reg <= HELD_MAX)
        else $error("table over capacity");
    pop_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (!out_valid_reg || out_take))
        else $error("item taken while result pending");
    scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (idx_reg < held_reg))
        else $error("scan beyond table");
    evict_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EV_ISS) |-> (held_reg == HELD_MAX))
        else $error("eviction below capacity");

endmodule
`default_nettype wire

// ===== test/testbench.sv =====
// ----------------------------------------------------------------------------
// Key occurrence counter testbench
// Drives count and read beats into the recency-ordered key table, predicts
// each result with a behavioural copy of the table, and compares every field.
// ----------------------------------------------------------------------------
module testbench
    import lkc_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH      = 64;
    localparam int IDLE_PCT   = 17;
    localparam int STALL_LIM  = 20000;
    localparam logic [31:0] CNT_MAX = 32'hFFFF_FFFF;

    logic             clk = 1'b0;
    logic             rst_n;
    logic             in_valid;
    logic             in_stall;
    logic             func;
    logic [KEY_W-1:0] key;
    logic [POS_W-1:0] position;
    logic             out_valid;
    logic             out_stall;
    logic             found;
    logic [KEY_W-1:0] entry_key;
    logic [CNT_W-1:0] entry_count;
    logic             evicted;
    logic [KEY_W-1:0] evicted_key;
    logic [CNT_W-1:0] evicted_count;
    logic [OCC_W-1:0] occupancy;

    lru_key_occurrence_counter dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .func(func), .key(key), .position(position),
        .out_valid(out_valid), .out_stall(out_stall),
        .found(found), .entry_key(entry_key), .entry_count(entry_count),
        .evicted(evicted), .evicted_key(evicted_key),
        .evicted_count(evicted_count), .occupancy(occupancy)
    );

    // recency-ordered model: index 0 is oldest
    logic [31:0] tbl_key[$];
    logic [31:0] tbl_cnt[$];
    result_t     pending[$];

    int  errors;
    int  idle_cycles;
    bit  quiet_tx;
    bit  quiet_rx;
    bit  hold_rx;
    int  hold_len;
    logic [31:0] hot_keys[8];

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic result_t predict_table(input op_t op, input logic [31:0] k,
                                              input logic [5:0] pos);
        result_t r;
        int idx;
        logic [31:0] c;
        r = '0;
        idx = -1;
        if (op == OP_READ)
        begin
            if (pos < tbl_key.size())
            begin
                r.found = 1'b1;
                r.entry_key = tbl_key[pos];
                r.entry_count = tbl_cnt[pos];
            end
        end
        else
        begin
            for (int i = 0; i < tbl_key.size(); i++)
                if (tbl_key[i] == k)
                    idx = i;
            if (idx >= 0)
            begin
                c = tbl_cnt[idx];
                if (c != CNT_MAX)
                    c = c + 1;
                tbl_key.delete(idx);
                tbl_cnt.delete(idx);
                tbl_key.push_back(k);
                tbl_cnt.push_back(c);
                r.found = 1'b1;
                r.entry_key = k;
                r.entry_count = c;
            end
            else
            begin
                tbl_key.push_back(k);
                tbl_cnt.push_back(32'd1);
                r.entry_key = k;
                r.entry_count = 32'd1;
                if (tbl_key.size() >= DEPTH)
                begin
                    r.evicted = 1'b1;
                    r.evicted_key = tbl_key.pop_front();
                    r.evicted_count = tbl_cnt.pop_front();
                end
            end
        end
        r.occupancy = OCC_W'(tbl_key.size());
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // sender: one beat, with random idle gaps
    task automatic send_beat(input op_t op, input logic [31:0] k, input logic [5:0] pos);
        while (!quiet_tx && $urandom_range(99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        func     <= op;
        key      <= k;
        position <= pos;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pending.push_back(predict_table(op, k, pos));
    endtask

    task automatic send_count(input logic [31:0] k);
        send_beat(OP_COUNT, k, 6'($urandom_range(63)));
    endtask

    task automatic send_read(input logic [5:0] pos);
        send_beat(OP_READ, $urandom(), pos);
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (hold_rx)
                out_stall <= 1'b1;
            else
                out_stall <= !quiet_rx && ($urandom_range(99) < IDLE_PCT);
        end
    end

    always @(posedge clk)
    begin
        if (hold_len > 0)
            hold_len--;
        hold_rx = hold_len > 0;
    end

    always @(posedge clk)
    begin
        result_t w;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending.size() == 0)
            begin
                $display("unexpected result beat at %0t", $realtime);
                errors++;
            end
            else
            begin
                w = pending.pop_front();
                if (found != w.found)
                    report_mismatch("found", 32'(found), 32'(w.found));
                if (entry_key != w.entry_key)
                    report_mismatch("entry_key", entry_key, w.entry_key);
                if (entry_count != w.entry_count)
                    report_mismatch("entry_count", entry_count, w.entry_count);
                if (evicted != w.evicted)
                    report_mismatch("evicted", 32'(evicted), 32'(w.evicted));
                if (evicted_key != w.evicted_key)
                    report_mismatch("evicted_key", evicted_key, w.evicted_key);
                if (evicted_count != w.evicted_count)
                    report_mismatch("evicted_count", evicted_count, w.evicted_count);
                if (occupancy != w.occupancy)
                    report_mismatch("occupancy", 32'(occupancy), 32'(w.occupancy));
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > STALL_LIM)
        begin
            $display("lru_key_occurrence_counter verification failed");
            $finish;
        end
    end

    task automatic test_reads_empty();
        send_read(6'd0);
        send_read(6'd63);
    endtask

    task automatic test_extremes();
        send_count(32'h0000_0000);
        send_count(32'hFFFF_FFFF);
        send_count(32'h0000_0000);
        send_count(32'hAAAA_5555);
        send_count(32'h5555_AAAA);
        send_count(32'hFFFF_FFFF);
        send_read(6'd0);
        send_read(6'd3);
        send_read(6'd4);
        send_read(6'd62);
    endtask

    // fill past capacity so the oldest entries go, then hit old and new keys
    task automatic test_eviction();
        for (int i = 0; i < 66; i++)
            send_count(32'h0A00_0000 + i);
        send_count(32'h0A00_0041);
        send_count(32'h0A00_0010);
        send_read(6'd0);
        send_read(6'd62);
        send_read(6'd63);
    endtask

    task automatic test_random(input int n);
        int sel;
        for (int i = 0; i < n; i++)
        begin
            sel = $urandom_range(99);
            if (sel < 45)
                send_count(hot_keys[$urandom_range(7)]);
            else if (sel < 60)
                send_count($urandom());
            else if (sel < 80)
                send_count(32'hC0A8_0000 + $urandom_range(90));
            else
                send_read(6'($urandom_range(63)));
        end
    endtask

    task automatic test_backpressure();
        fork
            hold_len = 300;
            for (int i = 0; i < 12; i++)
                send_count(32'hC0A8_0000 + $urandom_range(90));
        join
    endtask

    initial
    begin
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        func      = FUNC_COUNT;
        key       = '0;
        position  = '0;
        out_stall = 1'b0;
        errors    = 0;
        idle_cycles = 0;
        quiet_tx  = 1'b0;
        quiet_rx  = 1'b0;
        hold_rx   = 1'b0;
        hold_len  = 0;
        for (int i = 0; i < 8; i++)
            hot_keys[i] = $urandom();
        hot_keys[0] = 32'hFFFF_FFFF;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reads_empty();
        test_extremes();
        test_eviction();
        test_backpressure();
        test_random(300);
        quiet_tx = 1'b1;
        quiet_rx = 1'b1;
        test_random(150);
        quiet_tx = 1'b0;
        quiet_rx = 1'b0;
        test_random(250);
        in_valid <= 1'b0;

        while (pending.size() != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
        if (errors == 0)
            $display("lru_key_occurrence_counter verification clean");
        else
            $display("lru_key_occurrence_counter verification failed");
        $finish;
    end
endmodule

// ===== filelist.f =====
hw/rtl/lkc_pkg.sv
hw/rtl/lkc_front.sv
hw/rtl/lkc_back.sv
hw/rtl/lru_key_occurrence_counter.sv
test/testbench.sv
